// File: src/sexp_pkg.sv
// Shared types, kind codes and lookup tables for the s-expression tokenizer.
package sexp_pkg;

    // Datapath sizes
    localparam int NUMBER_WIDTH  = 32;
    localparam int KEYWORD_CHARS = 8;
    localparam int WIN_W         = KEYWORD_CHARS * 8;
    localparam int VALUE_W       = 32;
    localparam int TDATA_W       = 56;
    localparam int QUEUE_DEPTH   = 4;
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

    // Result kind codes
    typedef logic [4:0] kind_t;
    localparam kind_t KIND_EOF         = 5'd0;
    localparam kind_t KIND_PUNCT_FIRST = 5'd1;
    localparam kind_t KIND_NUMBER      = 5'd14;
    localparam kind_t KIND_SYMBOL      = 5'd15;
    localparam kind_t KIND_TEXT        = 5'd16;
    localparam kind_t KIND_DEFN        = 5'd17;
    localparam kind_t KIND_LET         = 5'd18;
    localparam kind_t KIND_FN          = 5'd19;
    localparam kind_t KIND_IF          = 5'd20;
    localparam kind_t KIND_PRINTLN     = 5'd21;
    localparam kind_t KIND_PRINT       = 5'd22;
    localparam kind_t KIND_TRUE        = 5'd23;
    localparam kind_t KIND_FALSE       = 5'd24;
    localparam kind_t KIND_NIL         = 5'd25;
    localparam kind_t KIND_BUILTIN     = 5'd26;
    localparam kind_t KIND_ERROR       = 5'd27;
    localparam kind_t KIND_BYTE        = 5'd28;

    // Character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_SYMBOL,
        MODE_STRING,
        MODE_ERROR
    } mode_t;

    // One result item
    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] number_value;
        logic               number_overflow;
        logic [7:0]         text_byte;
        logic [7:0]         text_length;
        logic               last_of_item;
    } result_t;

    // Results produced by one item, handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Punctuation characters, kind is position plus one
    localparam int PUNCT_COUNT = 13;
    localparam logic [7:0] PUNCT_CHARS [PUNCT_COUNT] = '{
        "(", ")", "[", "]", "*", "-", "+", "/", "&", "'", "=", "<", ">"
    };

    // Keyword and builtin table; text is right-justified, first character highest
    localparam int WORD_COUNT = 23;
    localparam logic [WIN_W-1:0] WORD_TEXT [WORD_COUNT] = '{
        "defn", "let", "fn", "if", "println", "print", "true", "false", "nil",
        "nil?", "empty?", "context!", "cons", "seq?", "list", "and", "or",
        "not", "mod", "nth", "size", "first", "rest"
    };
    localparam logic [7:0] WORD_LEN [WORD_COUNT] = '{
        8'd4, 8'd3, 8'd2, 8'd2, 8'd7, 8'd5, 8'd4, 8'd5, 8'd3,
        8'd4, 8'd6, 8'd8, 8'd4, 8'd4, 8'd4, 8'd3, 8'd2,
        8'd3, 8'd3, 8'd3, 8'd4, 8'd5, 8'd4
    };
    localparam kind_t WORD_KIND [WORD_COUNT] = '{
        KIND_DEFN, KIND_LET, KIND_FN, KIND_IF, KIND_PRINTLN, KIND_PRINT,
        KIND_TRUE, KIND_FALSE, KIND_NIL,
        KIND_BUILTIN, KIND_BUILTIN, KIND_BUILTIN, KIND_BUILTIN, KIND_BUILTIN,
        KIND_BUILTIN, KIND_BUILTIN, KIND_BUILTIN, KIND_BUILTIN, KIND_BUILTIN,
        KIND_BUILTIN, KIND_BUILTIN, KIND_BUILTIN, KIND_BUILTIN
    };

    // Punctuation kind of a character; KIND_EOF means not punctuation
    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        k = KIND_EOF;
        for (int i = 0; i < PUNCT_COUNT; i++) begin
            if (c == PUNCT_CHARS[i]) begin
                k = kind_t'(KIND_PUNCT_FIRST + i);
            end
        end
        return k;
    endfunction

    // Class a finished symbol by its window and length
    function automatic kind_t symbol_kind(input logic [WIN_W-1:0] window,
                                          input logic [7:0] len);
        kind_t k;
        k = KIND_SYMBOL;
        for (int i = WORD_COUNT - 1; i >= 0; i--) begin
            if (len == WORD_LEN[i] && window == WORD_TEXT[i]) begin
                k = WORD_KIND[i];
            end
        end
        return k;
    endfunction

endpackage

// File: src/sexp_scan.sv
// Scanner state and per-item token logic for the s-expression tokenizer.
module sexp_scan (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_fire,
    input  logic [7:0]     item_char,
    input  logic           item_end,
    output sexp_pkg::push_t push
);
    import sexp_pkg::*;

    mode_t                   mode_reg, mode_next;
    logic [NUMBER_WIDTH-1:0] acc_reg, acc_next;
    logic                    sat_reg, sat_next;
    logic [WIN_W-1:0]        window_reg, window_next;
    logic [7:0]              len_reg, len_next;

    logic                    is_digit, is_letter, is_extra, is_space, is_quote;
    logic                    is_symch, is_punct;
    kind_t                   pk;
    logic [NUMBER_WIDTH+3:0] acc_wide;
    logic [7:0]              len_inc;
    logic [WIN_W-1:0]        window_take;

    // Classify the incoming character
    assign is_digit  = (item_char >= "0") && (item_char <= "9");
    assign is_letter = ((item_char >= "a") && (item_char <= "z")) ||
                       ((item_char >= "A") && (item_char <= "Z"));
    assign is_extra  = (item_char == "*") || (item_char == "+") || (item_char == "-") ||
                       (item_char == "!") || (item_char == "?") || (item_char == "_");
    assign is_space  = (item_char == CH_SPACE) || (item_char == CH_NEWLINE);
    assign is_quote  = (item_char == CH_QUOTE);
    assign is_symch  = is_letter || is_digit || is_extra;
    assign pk        = punct_kind(item_char);
    assign is_punct  = (pk != KIND_EOF);

    // Multiply by ten and add the digit, with headroom to spot saturation
    assign acc_wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) +
                      {{NUMBER_WIDTH{1'b0}}, item_char[3:0]};

    // Saturating length and symbol window update
    assign len_inc     = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;
    assign window_take = (len_reg < 8'(KEYWORD_CHARS)) ?
                         {window_reg[WIN_W-9:0], item_char} : window_reg;

    // Next state
    always_comb
    begin
        logic start;
        start       = 1'b0;
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        sat_next    = sat_reg;
        window_next = window_reg;
        len_next    = len_reg;
        unique case (mode_reg)
            MODE_ERROR:
            begin
                mode_next = MODE_ERROR;
            end
            MODE_NUMBER:
            begin
                if (!item_end && is_digit)
                begin
                    if (|acc_wide[NUMBER_WIDTH+3:NUMBER_WIDTH])
                    begin
                        acc_next = {NUMBER_WIDTH{1'b1}};
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_wide[NUMBER_WIDTH-1:0];
                    end
                end
                else
                begin
                    start = 1'b1;
                end
            end
            MODE_SYMBOL:
            begin
                if (!item_end && is_symch)
                begin
                    window_next = window_take;
                    len_next    = len_inc;
                end
                else
                begin
                    start = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (item_end || is_quote)
                begin
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    len_next = len_inc;
                end
            end
            MODE_IDLE:
            begin
                start = 1'b1;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // Scan the character from idle
        if (start)
        begin
            if (item_end || is_space || is_punct)
            begin
                mode_next = MODE_IDLE;
            end
            else if (is_digit)
            begin
                mode_next = MODE_NUMBER;
                acc_next  = {{(NUMBER_WIDTH-4){1'b0}}, item_char[3:0]};
                sat_next  = 1'b0;
            end
            else if (is_letter)
            begin
                mode_next   = MODE_SYMBOL;
                window_next = {{(WIN_W-8){1'b0}}, item_char};
                len_next    = 8'd1;
            end
            else if (is_quote)
            begin
                mode_next = MODE_STRING;
                len_next  = 8'd0;
            end
            else
            begin
                mode_next = MODE_ERROR;
            end
        end
    end

    // Results of the item
    always_comb
    begin
        result_t lead, tail;
        logic    lead_valid, tail_valid, use_tail;
        lead       = '0;
        tail       = '0;
        lead_valid = 1'b0;
        tail_valid = 1'b0;
        use_tail   = 1'b0;
        unique case (mode_reg)
            MODE_ERROR:
            begin
                use_tail = 1'b0;
            end
            MODE_NUMBER:
            begin
                if (item_end || !is_digit)
                begin
                    lead_valid           = 1'b1;
                    lead.kind            = KIND_NUMBER;
                    lead.number_value    = VALUE_W'(acc_reg);
                    lead.number_overflow = sat_reg;
                    use_tail             = 1'b1;
                end
            end
            MODE_SYMBOL:
            begin
                lead_valid = 1'b1;
                if (!item_end && is_symch)
                begin
                    lead.kind      = KIND_BYTE;
                    lead.text_byte = item_char;
                end
                else
                begin
                    lead.kind        = symbol_kind(window_reg, len_reg);
                    lead.text_length = len_reg;
                    use_tail         = 1'b1;
                end
            end
            MODE_STRING:
            begin
                lead_valid = 1'b1;
                if (item_end || is_quote)
                begin
                    lead.kind        = KIND_TEXT;
                    lead.text_length = len_reg;
                    use_tail         = item_end;
                end
                else
                begin
                    lead.kind      = KIND_BYTE;
                    lead.text_byte = item_char;
                end
            end
            MODE_IDLE:
            begin
                use_tail = 1'b1;
            end
            default:
            begin
                use_tail = 1'b0;
            end
        endcase

        if (use_tail)
        begin
            if (item_end)
            begin
                tail_valid = 1'b1;
                tail.kind  = KIND_EOF;
            end
            else if (is_punct)
            begin
                tail_valid = 1'b1;
                tail.kind  = pk;
            end
            else if (is_letter)
            begin
                tail_valid     = 1'b1;
                tail.kind      = KIND_BYTE;
                tail.text_byte = item_char;
            end
            else if (!(is_space || is_digit || is_quote))
            begin
                tail_valid = 1'b1;
                tail.kind  = KIND_ERROR;
            end
        end

        // Pack into the queue slots, mark the final one
        push.count  = {1'b0, lead_valid} + {1'b0, tail_valid};
        push.first  = lead_valid ? lead : tail;
        push.second = tail;
        push.first.last_of_item  = (push.count == 2'd1);
        push.second.last_of_item = 1'b1;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= '0;
            sat_reg    <= 1'b0;
            window_reg <= '0;
            len_reg    <= '0;
        end
        else if (item_fire)
        begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            sat_reg    <= sat_next;
            window_reg <= window_next;
            len_reg    <= len_next;
        end
    end

    // The error mode is final until reset
    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ERROR) |=> (mode_reg == MODE_ERROR))
        else $error("scanner left the error mode");

    // No results come out of the error mode
    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ERROR) |-> (push.count == 2'd0))
        else $error("result produced in error mode");

    // Two results: only the second one closes the item
    a_last_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (push.second.last_of_item && !push.first.last_of_item))
        else $error("last marker on wrong result");

endmodule

// File: src/sexp_outq.sv
// Result queue of the s-expression tokenizer: takes up to two items, gives one per cycle while head_ready is high.
module sexp_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  sexp_pkg::push_t   push,
    output logic              room,
    output logic              head_valid,
    input  logic              head_ready,
    output sexp_pkg::result_t head
);
    import sexp_pkg::*;

    result_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    // Pop on a completed output handshake
    assign head_valid = (count_reg != '0);
    assign pop        = head_valid && head_ready;
    assign head       = mem[rd_ptr_reg];

    // Room for two more items after this cycle's pop
    assign room = (count_reg <= CNT_W'(QUEUE_DEPTH - 2)) ||
                  ((count_reg == CNT_W'(QUEUE_DEPTH - 1)) && pop);

    // Advance pointers and fill count
    always_comb
    begin
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item's results
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    // Fill count never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    // Results only arrive when there is room for them
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without room");

    // A pop without push lowers the count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (push.count == 2'd0)) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("queue count lost track of a pop");

endmodule

// File: src/s_expression_tokenizer_top.sv
// Top level of the s-expression tokenizer: input register, scanner and result queue.
//
// The block takes one character (or an end mark in s_tuser) per input item and gives
// token results on the master side, one result per cycle while m_tready is high. An
// input item is held in the input register, scanned once the queue has room for two
// results, and its zero, one or two results enter a four-entry queue, which offers the
// first result at its head. Input items are taken every cycle as long as the queue has
// room for two results; the output port moves one result per cycle while m_tready is
// high, so a sustained rate of one item per cycle holds when items average at most one
// result, and an item that ends a token and starts another gives two results. After a
// bad character the block gives an error result and then takes items without giving
// results until reset.
module s_expression_tokenizer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] char_code
    input  logic                            s_tuser,   // [0] is_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sexp_pkg::TDATA_W-1:0]    m_tdata,   // [31:0] number_value,
                                                       // [32] number_overflow,
                                                       // [40:33] text_byte,
                                                       // [48:41] text_length, zero above
    output logic [4:0]                      m_tuser,   // [4:0] kind
    output logic                            m_tlast    // last_of_item
);
    import sexp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_end_reg;
    logic       fire;
    logic       room;
    push_t      push_live;
    push_t      push;
    result_t    head;

    // Scan the held item once the queue can take its results
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the input item payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tuser;
        end
    end

    sexp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_fire (fire),
        .item_char (in_char_reg),
        .item_end  (in_end_reg),
        .push      (push_live)
    );

    assign push = fire ? push_live : '0;

    sexp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    // Map the head result onto the master side
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_item;
    assign m_tdata = {{(TDATA_W - 49){1'b0}}, head.text_length, head.text_byte,
                      head.number_overflow, head.number_value};

endmodule
